// ===== src/kbs_pkg.sv =====
// Shared types and constants for the keyword byte substitution block.
// Used by kbs_sweep, kbs_table and keyword_byte_substitution.
package kbs_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned KEY_WORD_W = 64;
	localparam int unsigned KEY_W      = 2 * KEY_WORD_W;
	localparam int unsigned LEN_W      = 5;
	localparam int unsigned INDEX_W    = 2;
	localparam logic [BYTE_W-1:0] LAST_BYTE = 8'hFF;

	typedef enum logic [INDEX_W-1:0] {
		REG_KEY_LOW  = 2'd0,
		REG_KEY_HIGH = 2'd1,
		REG_KEY_LEN  = 2'd2,
		REG_DIR      = 2'd3
	} reg_index_t;

	// One table update: enc[value] = pos and dec[pos] = value
	typedef struct packed {
		logic              we;
		logic [BYTE_W-1:0] value;
		logic [BYTE_W-1:0] pos;
	} tbl_wr_t;

endpackage

// ===== src/kbs_sweep.sv =====
// Table rebuild sequencer: walks all byte values in ascending order and
// issues one encrypt/decrypt table update per cycle. Depends on kbs_pkg.
module kbs_sweep #(
	parameter int unsigned MAX_KEY_BYTES = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                restart,
	input  logic [kbs_pkg::KEY_W-1:0]           key,
	input  logic [kbs_pkg::LEN_W-1:0]           key_len,
	output logic                                active,
	output logic                                dup,
	output kbs_pkg::tbl_wr_t                    wr
);

	logic                          active_q;
	logic                          dup_q;
	logic [kbs_pkg::BYTE_W-1:0]    value_q;
	logic [kbs_pkg::BYTE_W-1:0]    free_q;
	logic [MAX_KEY_BYTES-1:0]      hit;
	logic [kbs_pkg::BYTE_W-1:0]    hit_idx;
	logic                          any_hit;
	logic                          multi_hit;
	logic [kbs_pkg::BYTE_W-1:0]    pos;

	always_comb begin
		hit     = '0;
		hit_idx = '0;
		for (int i = 0; i < MAX_KEY_BYTES; i++) begin
			hit[i] = (kbs_pkg::LEN_W'(i) < key_len) &&
			         (key[i*kbs_pkg::BYTE_W +: kbs_pkg::BYTE_W] == value_q);
		end
		for (int i = MAX_KEY_BYTES - 1; i >= 0; i--) begin
			if (hit[i]) begin
				hit_idx = kbs_pkg::BYTE_W'(i);
			end
		end
		any_hit   = |hit;
		multi_hit = $countones(hit) > 1;
		pos = any_hit ? hit_idx : (kbs_pkg::BYTE_W'(key_len) + free_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b1;
			dup_q    <= 1'b0;
			value_q  <= '0;
			free_q   <= '0;
		end else if (restart) begin
			active_q <= 1'b1;
			dup_q    <= 1'b0;
			value_q  <= '0;
			free_q   <= '0;
		end else if (active_q) begin
			if (multi_hit) begin
				dup_q <= 1'b1;
			end
			if (!any_hit) begin
				free_q <= free_q + kbs_pkg::BYTE_W'(1);
			end
			value_q <= value_q + kbs_pkg::BYTE_W'(1);
			if (value_q == kbs_pkg::LAST_BYTE) begin
				active_q <= 1'b0;
			end
		end
	end

	assign active   = active_q;
	assign dup      = dup_q;
	assign wr.we    = active_q;
	assign wr.value = value_q;
	assign wr.pos   = pos;

endmodule

// ===== src/kbs_table.sv =====
// Encrypt and decrypt lookup memories, 256 bytes each, with a registered read.
// Depends on kbs_pkg for the update request type.
module kbs_table (
	input  logic                          clk,
	input  kbs_pkg::tbl_wr_t              wr,
	input  logic                          rd_en,
	input  logic [kbs_pkg::BYTE_W-1:0]    rd_addr,
	output logic [kbs_pkg::BYTE_W-1:0]    enc_data,
	output logic [kbs_pkg::BYTE_W-1:0]    dec_data
);

	logic [kbs_pkg::BYTE_W-1:0] enc_mem [2**kbs_pkg::BYTE_W];
	logic [kbs_pkg::BYTE_W-1:0] dec_mem [2**kbs_pkg::BYTE_W];
	logic [kbs_pkg::BYTE_W-1:0] enc_q;
	logic [kbs_pkg::BYTE_W-1:0] dec_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			enc_mem[wr.value] <= wr.pos;
			dec_mem[wr.pos]   <= wr.value;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			enc_q <= enc_mem[rd_addr];
			dec_q <= dec_mem[rd_addr];
		end
	end

	assign enc_data = enc_q;
	assign dec_data = dec_q;

endmodule

// ===== src/keyword_byte_substitution.sv =====
// Keyword byte substitution cipher: top level with registers and lookup.
// Depends on kbs_pkg, kbs_sweep and kbs_table.
//
// One byte is taken per clock whenever busy is low; its result appears on
// result_byte and key_invalid with done high for exactly one cycle, in the cycle
// after the request, and the receiver cannot hold it off. Lookup goes through
// two 256-entry memories (byte to position, position to byte) with a
// registered read. After reset and after every register write the memories are
// rebuilt by a sweep over all 256 byte values, one per cycle, and busy stays
// high until the sweep is through. With an empty or repeating keyword the result is
// zero and key_invalid is set.
module keyword_byte_substitution #(
	parameter int unsigned MAX_KEY_BYTES = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [kbs_pkg::BYTE_W-1:0]         data_byte,
	output logic                               done,
	output logic [kbs_pkg::BYTE_W-1:0]         result_byte,
	output logic                               key_invalid,
	input  logic                               wr_en,
	input  logic [kbs_pkg::INDEX_W-1:0]        wr_index,
	input  logic [kbs_pkg::KEY_WORD_W-1:0]     wr_data
);

	logic [kbs_pkg::KEY_WORD_W-1:0] key_low_q;
	logic [kbs_pkg::KEY_WORD_W-1:0] key_high_q;
	logic [kbs_pkg::LEN_W-1:0]      key_len_q;
	logic                           dir_q;
	logic                           valid_s1;
	logic [kbs_pkg::LEN_W-1:0]      len_eff;
	logic                           sweep_active;
	logic                           sweep_dup;
	logic                           invalid;
	logic                           accept;
	kbs_pkg::tbl_wr_t               tbl_wr;
	logic [kbs_pkg::BYTE_W-1:0]     enc_data;
	logic [kbs_pkg::BYTE_W-1:0]     dec_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
			key_len_q  <= kbs_pkg::LEN_W'(1);
			dir_q      <= 1'b0;
		end else if (wr_en) begin
			unique case (kbs_pkg::reg_index_t'(wr_index))
				kbs_pkg::REG_KEY_LOW:  key_low_q  <= wr_data;
				kbs_pkg::REG_KEY_HIGH: key_high_q <= wr_data;
				kbs_pkg::REG_KEY_LEN:  key_len_q  <= wr_data[kbs_pkg::LEN_W-1:0];
				kbs_pkg::REG_DIR:      dir_q      <= wr_data[0];
			endcase
		end
	end

	assign len_eff = (key_len_q > kbs_pkg::LEN_W'(MAX_KEY_BYTES)) ?
	                 kbs_pkg::LEN_W'(MAX_KEY_BYTES) : key_len_q;

	kbs_sweep #(
		.MAX_KEY_BYTES(MAX_KEY_BYTES)
	) u_sweep (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (wr_en),
		.key     ({key_high_q, key_low_q}),
		.key_len (len_eff),
		.active  (sweep_active),
		.dup     (sweep_dup),
		.wr      (tbl_wr)
	);

	assign busy   = sweep_active;
	assign accept = start && !sweep_active;

	kbs_table u_table (
		.clk      (clk),
		.wr       (tbl_wr),
		.rd_en    (accept),
		.rd_addr  (data_byte),
		.enc_data (enc_data),
		.dec_data (dec_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	assign invalid     = (len_eff == '0) || sweep_dup;
	assign done        = valid_s1;
	assign key_invalid = invalid;
	assign result_byte = invalid ? '0 : (dir_q ? dec_data : enc_data);

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for keyword_byte_substitution.
// Depends on kbs_pkg; predicts every result from its own copy of the registers
// and checks each strobed result against the oldest outstanding request.
`timescale 1ns / 1ps

module tb;

	localparam int unsigned KEY_MAX     = 16;
	localparam int unsigned IDLE_LIMIT  = 2000;
	localparam int unsigned RAND_ITEMS  = 800;
	localparam int unsigned SHOW_ERRORS = 10;

	typedef struct packed {
		logic [kbs_pkg::BYTE_W-1:0] result_byte;
		logic                       key_invalid;
	} subst_t;

	logic                           clk;
	logic                           arst_n    = 1'b0;
	logic                           start     = 1'b0;
	logic [kbs_pkg::BYTE_W-1:0]     data_byte = '0;
	logic                           wr_en     = 1'b0;
	logic [kbs_pkg::INDEX_W-1:0]    wr_index  = '0;
	logic [kbs_pkg::KEY_WORD_W-1:0] wr_data   = '0;
	logic                           busy;
	logic                           done;
	logic [kbs_pkg::BYTE_W-1:0]     result_byte;
	logic                           key_invalid;

	logic [kbs_pkg::KEY_WORD_W-1:0] key_low_q  = '0;
	logic [kbs_pkg::KEY_WORD_W-1:0] key_high_q = '0;
	logic [kbs_pkg::LEN_W-1:0]      key_len_q  = 5'd1;
	logic                           dir_q      = 1'b0;

	subst_t      expected_subst[$];
	int unsigned errors      = 0;
	int unsigned idle_cycles = 0;

	keyword_byte_substitution dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.data_byte   (data_byte),
		.done        (done),
		.result_byte (result_byte),
		.key_invalid (key_invalid),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic subst_t substitute_byte(input logic [kbs_pkg::BYTE_W-1:0] data);
		logic [kbs_pkg::BYTE_W-1:0] key [KEY_MAX];
		logic                       used [256];
		logic [kbs_pkg::KEY_W-1:0]  kw;
		int unsigned                len, below, pos, target, i, v;
		subst_t                     r;
		r.result_byte = '0;
		r.key_invalid = 1'b0;
		kw = {key_high_q, key_low_q};
		len = (key_len_q > KEY_MAX) ? KEY_MAX : key_len_q;
		for (v = 0; v < 256; v++)
			used[v] = 1'b0;
		if (len == 0)
			r.key_invalid = 1'b1;
		for (i = 0; i < len; i++) begin
			key[i] = kw[i*8 +: 8];
			if (used[key[i]])
				r.key_invalid = 1'b1;
			used[key[i]] = 1'b1;
		end
		if (!r.key_invalid) begin
			if (!dir_q) begin
				if (used[data]) begin
					for (i = 0; i < len; i++)
						if (key[i] == data)
							r.result_byte = i[7:0];
				end else begin
					below = 0;
					for (i = 0; i < len; i++)
						if (key[i] < data)
							below++;
					r.result_byte = 8'(len + data - below);
				end
			end else if (data < len) begin
				r.result_byte = key[data];
			end else begin
				target = data - len;
				pos = 0;
				for (v = 0; v < 256; v++) begin
					if (!used[v]) begin
						if (pos == target) begin
							r.result_byte = v[7:0];
							break;
						end
						pos++;
					end
				end
			end
		end
		return r;
	endfunction

	function automatic logic [kbs_pkg::KEY_WORD_W-1:0] with_noise(
			input logic [kbs_pkg::KEY_WORD_W-1:0] value, input int unsigned keep);
		logic [kbs_pkg::KEY_WORD_W-1:0] mask;
		mask = (64'd1 << keep) - 64'd1;
		return ({$urandom(), $urandom()} & ~mask) | (value & mask);
	endfunction

	task automatic note_error(input string what, input subst_t want, input subst_t got);
		if (errors < SHOW_ERRORS)
			$display({"tb: %s at %0t: expected result_byte=%02h key_invalid=%0b,",
				" got result_byte=%02h key_invalid=%0b"},
				what, $realtime, want.result_byte, want.key_invalid,
				got.result_byte, got.key_invalid);
		errors++;
	endtask

	task automatic write_reg(input kbs_pkg::reg_index_t idx,
			input logic [kbs_pkg::KEY_WORD_W-1:0] value);
		start <= 1'b0;
		while (expected_subst.size() != 0)
			@(posedge clk);
		while (busy)
			@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= value;
		@(posedge clk);
		case (idx)
			kbs_pkg::REG_KEY_LOW:  key_low_q  = value;
			kbs_pkg::REG_KEY_HIGH: key_high_q = value;
			kbs_pkg::REG_KEY_LEN:  key_len_q  = value[kbs_pkg::LEN_W-1:0];
			kbs_pkg::REG_DIR:      dir_q      = value[0];
		endcase
		wr_en <= 1'b0;
		do @(posedge clk); while (busy);
	endtask

	task automatic set_key(input logic [kbs_pkg::KEY_W-1:0] kw, input int unsigned len,
			input bit dir);
		write_reg(kbs_pkg::REG_KEY_LOW, kw[63:0]);
		write_reg(kbs_pkg::REG_KEY_HIGH, kw[127:64]);
		write_reg(kbs_pkg::REG_KEY_LEN, with_noise(64'(len), kbs_pkg::LEN_W));
		write_reg(kbs_pkg::REG_DIR, with_noise(64'(dir), 1));
	endtask

	task automatic send_request(input logic [kbs_pkg::BYTE_W-1:0] b);
		start     <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (busy);
		expected_subst.insert(expected_subst.size(), substitute_byte(b));
	endtask

	task automatic idle_gap(input bit quiet);
		int unsigned r, n;
		r = $urandom_range(0, 99);
		if (quiet || r < 50)
			n = 0;
		else if (r < 90)
			n = $urandom_range(1, 3);
		else if (r < 98)
			n = $urandom_range(4, 10);
		else
			n = $urandom_range(20, 60);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic fill_distinct_key(output logic [kbs_pkg::KEY_W-1:0] kw);
		bit          taken [256];
		logic [7:0]  b;
		int unsigned i;
		for (i = 0; i < 256; i++)
			taken[i] = 1'b0;
		for (i = 0; i < KEY_MAX; i++) begin
			do b = 8'($urandom_range(0, 255)); while (taken[b]);
			taken[b] = 1'b1;
			kw[i*8 +: 8] = b;
		end
	endtask

	task automatic test_reset_defaults();
		send_request(8'h00);
		send_request(8'hFF);
		send_request(8'h7F);
		write_reg(kbs_pkg::REG_DIR, 64'd1);
		send_request(8'h00);
		send_request(8'hFF);
	endtask

	task automatic test_full_key();
		logic [kbs_pkg::KEY_W-1:0] kw;
		kw = {64'hFE7F_3F1F_0F07_0302, 64'h8040_2010_0801_FF00};
		set_key(kw, KEY_MAX, 1'b0);
		send_request(8'h00);
		send_request(8'hFF);
		send_request(8'hFE);
		send_request(8'h80);
		send_request(8'h81);
		send_request(8'h7E);
		write_reg(kbs_pkg::REG_DIR, 64'd1);
		send_request(8'd0);
		send_request(8'd1);
		send_request(8'd15);
		send_request(8'd16);
		send_request(8'd255);
		send_request(8'd100);
	endtask

	task automatic test_invalid_key();
		set_key('0, 0, 1'b0);
		send_request(8'h55);
		set_key(128'h0000_0000_0042_0042, 3, 1'b1);
		send_request(8'h01);
		write_reg(kbs_pkg::REG_DIR, 64'd0);
		send_request(8'h42);
	endtask

	task automatic test_overlong_length();
		logic [kbs_pkg::KEY_W-1:0] kw;
		kw = {64'h0F0E_0D0C_0B0A_0908, 64'h0706_0504_0302_01FF};
		set_key(kw, 31, 1'b0);
		send_request(8'hFF);
		write_reg(kbs_pkg::REG_DIR, 64'd1);
		send_request(8'd255);
		write_reg(kbs_pkg::REG_KEY_LEN, with_noise(64'd17, kbs_pkg::LEN_W));
		send_request(8'd16);
	endtask

	task automatic test_random_traffic();
		logic [kbs_pkg::KEY_W-1:0] kw;
		int unsigned               total, n, k, len, eff_len, i, j;
		bit                        dir, quiet;
		logic [7:0]                b;
		total = 0;
		while (total < RAND_ITEMS) begin
			fill_distinct_key(kw);
			k = $urandom_range(0, 9);
			if (k == 0) begin
				len = 0;
			end else if (k == 1) begin
				len = $urandom_range(2, KEY_MAX);
				i = $urandom_range(1, len - 1);
				j = $urandom_range(0, i - 1);
				kw[i*8 +: 8] = kw[j*8 +: 8];
			end else if (k == 2) begin
				len = $urandom_range(KEY_MAX + 1, 31);
			end else begin
				len = $urandom_range(1, KEY_MAX);
			end
			eff_len = (len > KEY_MAX) ? KEY_MAX : len;
			dir = 1'($urandom_range(0, 1));
			quiet = ($urandom_range(0, 3) == 0);
			set_key(kw, len, dir);
			n = $urandom_range(10, 60);
			repeat (n) begin
				if (eff_len > 0 && $urandom_range(0, 2) == 0)
					b = dir ? 8'($urandom_range(0, eff_len))
						: kw[$urandom_range(0, eff_len - 1)*8 +: 8];
				else
					b = 8'($urandom_range(0, 255));
				send_request(b);
				idle_gap(quiet);
			end
			total += n;
		end
	endtask

	always @(posedge clk) begin : check_results
		subst_t want, got;
		if (arst_n && done) begin
			got.result_byte = result_byte;
			got.key_invalid = key_invalid;
			if (expected_subst.size() == 0) begin
				want = '0;
				note_error("result with no request", want, got);
			end else begin
				want = expected_subst.pop_front();
				if (got.result_byte !== want.result_byte ||
				    got.key_invalid !== want.key_invalid)
					note_error("mismatch", want, got);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || wr_en)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (busy);
		test_reset_defaults();
		test_full_key();
		test_invalid_key();
		test_overlong_length();
		test_random_traffic();
		start <= 1'b0;
		while (expected_subst.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (errors == 0 && expected_subst.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
